>>> hdl/bis_pkg.sv
// Package for the bilinear image scaler: shared constants, defaults and register codes.
// No dependencies; every other file of the block imports it.
package bis_pkg;

  // Fixed field widths of the streaming items and of the register port.
  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 4;

  // The scale factor is unsigned Q4.12.
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam int SIZE_REG_W = 9;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 12;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Reset values of the configuration registers.
  localparam logic [SIZE_REG_W-1:0] RST_SRC_WIDTH  = 9'd256;
  localparam logic [SIZE_REG_W-1:0] RST_SRC_HEIGHT = 9'd256;
  localparam logic [SCALE_W-1:0]    RST_SCALE      = 16'd2048;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_SCALE      = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  // Item kinds carried in the input tuser.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

endpackage

>>> hdl/bilinear_image_scaler.sv
// Top level of the bilinear image scaler: front, queue and back.
// Depends on bis_pkg, bis_front, bis_queue and bis_back.
//
//   Channel   Direction  Handshake                 Content
//   s_*       in         s_tvalid / s_tready       load or compute transaction
//   m_*       out        m_tvalid / m_tready       one result per compute transaction
//   apb       in         psel, penable, pready     source width, height, scale factor
//
// One transaction is taken per cycle while the queue is not full; loads and computes may
// follow back to back. With an empty queue a result passes through the division stages,
// the store read, the vertical and horizontal passes and the result register.
// Reset is synchronous; no clearing pass is needed as the store has no reset value.
// A stalled m_tready freezes the back; the four-entry queue then fills before
// s_tready falls.
module bilinear_image_scaler #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bis_pkg::ADDR_W-1:0]  paddr,
  input  logic [bis_pkg::CFG_W-1:0]   pwdata,
  output logic [bis_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,  // col, row, pixel_in
  input  logic                        s_tuser,  // action
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,  // pixel_out
  output logic                        m_tuser   // error
);
  import bis_pkg::*;

  localparam int SWW = $clog2(MAX_WIDTH) + 1;
  localparam int SHW = $clog2(MAX_HEIGHT) + 1;
  localparam int NW  = 8 + ((SWW > SHW) ? SWW : SHW) + FRAC_BITS;

  typedef struct packed {
    logic           load;
    logic [7:0]     col;
    logic [7:0]     row;
    logic [7:0]     pix;
    logic           err;
    logic [NW-1:0]  numx;
    logic [NW-1:0]  numy;
    logic [SWW-1:0] dx;
    logic [SHW-1:0] dy;
  } req_t;

  req_t           push_item;
  req_t           head;
  logic           push;
  logic           full;
  logic           empty;
  logic           pop;
  logic [SWW-1:0] sw_last;
  logic [SHW-1:0] sh_last;

  assign pready   = 1'b1;
  assign s_tready = !full;

  bis_front #(
    .item_t(req_t), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS(FRAC_BITS), .SWW(SWW), .SHW(SHW), .NW(NW)
  ) u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .in_valid(s_tvalid), .in_action(s_tuser),
    .in_col(s_tdata[7:0]), .in_row(s_tdata[15:8]), .in_pix(s_tdata[23:16]),
    .push, .push_item, .full, .sw_last, .sh_last
  );

  bis_queue #(.item_t(req_t), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_item, .full, .pop, .empty, .head
  );

  bis_back #(
    .item_t(req_t), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS(FRAC_BITS), .SWW(SWW), .SHW(SHW), .NW(NW)
  ) u_back (
    .clk, .rst, .empty, .head, .pop, .sw_last, .sh_last,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_pix(m_tdata), .out_err(m_tuser)
  );

endmodule

>>> hdl/bis_queue.sv
// Short first-in first-out queue that parts the front from the back.
// Depends on bis_pkg for its default depth.
module bis_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = bis_pkg::QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);
  import bis_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage is written without reset; only the pointers and the count are control state.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/bis_front.sv
// Front of the scaler: configuration registers, output size, range check and
// division operands for each accepted transaction. Depends on bis_pkg.
module bis_front #(
  parameter type item_t     = logic,
  parameter int  MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int  FRAC_BITS  = bis_pkg::DEF_FRAC_BITS,
  parameter int  SWW        = $clog2(MAX_WIDTH) + 1,
  parameter int  SHW        = $clog2(MAX_HEIGHT) + 1,
  parameter int  NW         = 8 + ((SWW > SHW) ? SWW : SHW) + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bis_pkg::ADDR_W-1:0]    paddr,
  input  logic [bis_pkg::CFG_W-1:0]     pwdata,
  output logic [bis_pkg::CFG_W-1:0]     prdata,
  input  logic                          in_valid,
  input  logic                          in_action,
  input  logic [bis_pkg::COORD_W-1:0]   in_col,
  input  logic [bis_pkg::COORD_W-1:0]   in_row,
  input  logic [bis_pkg::PIX_W-1:0]     in_pix,
  output logic                          push,
  output item_t                         push_item,
  input  logic                          full,
  output logic [SWW-1:0]                sw_last,
  output logic [SHW-1:0]                sh_last
);
  import bis_pkg::*;

  logic [SIZE_REG_W-1:0] src_width;
  logic [SIZE_REG_W-1:0] src_height;
  logic [SCALE_W-1:0]    scale;
  cfg_reg_t              reg_sel;
  logic                  cfg_write;

  logic [SWW-1:0]         sw_clamp;
  logic [SHW-1:0]         sh_clamp;
  logic [SWW+SCALE_W-1:0] ow_prod;
  logic [SHW+SCALE_W-1:0] oh_prod;
  logic [SWW-1:0]         out_w;
  logic [SHW-1:0]         out_h;
  logic                   out_of_range;

  assign reg_sel   = cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RST_SRC_WIDTH;
      src_height <= RST_SRC_HEIGHT;
      scale      <= RST_SCALE;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SRC_WIDTH:  src_width  <= pwdata[SIZE_REG_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[SIZE_REG_W-1:0];
        REG_SCALE:      scale      <= pwdata[SCALE_W-1:0];
        default:        scale      <= scale;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_SRC_WIDTH:  prdata = CFG_W'(src_width);
      REG_SRC_HEIGHT: prdata = CFG_W'(src_height);
      REG_SCALE:      prdata = CFG_W'(scale);
      default:        prdata = '0;
    endcase
  end

  // Source sizes saturate at the store size; output sizes follow from the factor and saturate likewise.
  assign sw_clamp = (32'(src_width) > 32'(MAX_WIDTH)) ? SWW'(MAX_WIDTH) : SWW'(src_width);
  assign sh_clamp = (32'(src_height) > 32'(MAX_HEIGHT)) ? SHW'(MAX_HEIGHT) : SHW'(src_height);
  assign ow_prod  = (SWW+SCALE_W)'(sw_clamp) * (SWW+SCALE_W)'(scale);
  assign oh_prod  = (SHW+SCALE_W)'(sh_clamp) * (SHW+SCALE_W)'(scale);
  assign out_w = ((ow_prod >> SCALE_FRAC) > (SWW+SCALE_W)'(MAX_WIDTH)) ?
                 SWW'(MAX_WIDTH) : SWW'(ow_prod >> SCALE_FRAC);
  assign out_h = ((oh_prod >> SCALE_FRAC) > (SHW+SCALE_W)'(MAX_HEIGHT)) ?
                 SHW'(MAX_HEIGHT) : SHW'(oh_prod >> SCALE_FRAC);

  // The last source indices are only used deep in the back, so they are registered.
  always_ff @(posedge clk) begin
    sw_last <= sw_clamp - 1'b1;
    sh_last <= sh_clamp - 1'b1;
  end

  assign out_of_range = (32'(in_col) >= 32'(out_w)) || (32'(in_row) >= 32'(out_h));
  assign push         = in_valid && !full;

  // Classify the transaction and build the numerators and divisors.
  always_comb begin
    push_item      = '0;
    push_item.load = (in_action == ACT_LOAD);
    push_item.col  = in_col;
    push_item.row  = in_row;
    push_item.pix  = in_pix;
    push_item.err  = (in_action == ACT_COMPUTE) && out_of_range;
    push_item.numx = NW'(NW'(in_col) * NW'(sw_clamp)) << FRAC_BITS;
    push_item.numy = NW'(NW'(in_row) * NW'(sh_clamp)) << FRAC_BITS;
    push_item.dx   = push_item.err ? SWW'(1) : out_w;
    push_item.dy   = push_item.err ? SHW'(1) : out_h;
  end

endmodule

>>> hdl/bis_back.sv
// Back of the scaler: pipelined coordinate division, banked frame store and
// interpolation datapath with a registered result. Depends on bis_pkg.
module bis_back #(
  parameter type item_t     = logic,
  parameter int  MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int  FRAC_BITS  = bis_pkg::DEF_FRAC_BITS,
  parameter int  SWW        = $clog2(MAX_WIDTH) + 1,
  parameter int  SHW        = $clog2(MAX_HEIGHT) + 1,
  parameter int  NW         = 8 + ((SWW > SHW) ? SWW : SHW) + FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  item_t                       head,
  output logic                        pop,
  input  logic [SWW-1:0]              sw_last,
  input  logic [SHW-1:0]              sh_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bis_pkg::PIX_W-1:0]   out_pix,
  output logic                        out_err
);
  import bis_pkg::*;

  localparam int LW    = SWW - 1;
  localparam int LH    = SHW - 1;
  localparam int BCW   = (LW > 1) ? LW - 1 : 1;
  localparam int BRW   = (LH > 1) ? LH - 1 : 1;
  localparam int BANK_D = 2 ** (BCW + BRW);
  localparam int FW    = FRAC_BITS + 1;
  localparam int PW    = PIX_W + FW;
  localparam int MW    = PW + FW;

  typedef struct packed {
    logic             valid;
    logic             load;
    logic             err;
    logic [7:0]       col;
    logic [7:0]       row;
    logic [7:0]       pix;
    logic [NW-1:0]    numx;
    logic [NW-1:0]    numy;
    logic [SWW-1:0]   dx;
    logic [SHW-1:0]   dy;
    logic [SWW-1:0]   remx;
    logic [SHW-1:0]   remy;
    logic [NW-1:0]    qx;
    logic [NW-1:0]    qy;
  } div_stage_t;

  logic       advance;
  div_stage_t st [NW+1];

  // The whole back moves together whenever the result register can take a value.
  assign advance = !out_valid || out_ready;
  assign pop     = advance && !empty;

  // Stage zero is the queue head with cleared remainders and quotients.
  always_comb begin
    st[0]       = '0;
    st[0].valid = !empty;
    st[0].load  = head.load;
    st[0].err   = head.err;
    st[0].col   = head.col;
    st[0].row   = head.row;
    st[0].pix   = head.pix;
    st[0].numx  = head.numx;
    st[0].numy  = head.numy;
    st[0].dx    = head.dx;
    st[0].dy    = head.dy;
  end

  // Restoring division, one quotient bit per stage for both coordinates.
  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [SWW:0] rx;
    logic [SHW:0] ry;
    logic         gx;
    logic         gy;
    div_stage_t   nx;

    always_comb begin
      rx      = {st[i].remx, st[i].numx[NW-1]};
      ry      = {st[i].remy, st[i].numy[NW-1]};
      gx      = (rx >= {1'b0, st[i].dx});
      gy      = (ry >= {1'b0, st[i].dy});
      nx      = st[i];
      nx.remx = gx ? SWW'(rx - {1'b0, st[i].dx}) : SWW'(rx);
      nx.remy = gy ? SHW'(ry - {1'b0, st[i].dy}) : SHW'(ry);
      nx.qx   = {st[i].qx[NW-2:0], gx};
      nx.qy   = {st[i].qy[NW-2:0], gy};
      nx.numx = st[i].numx << 1;
      nx.numy = st[i].numy << 1;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].valid <= 1'b0;
      end else if (advance) begin
        st[i+1] <= nx;
      end
    end
  end

  // Integer parts, fractions and the four neighbour addresses.
  logic [LW-1:0]        kx;
  logic [LH-1:0]        ky;
  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic [LW:0]          kx_inc;
  logic [LH:0]          ky_inc;
  logic                 load_ok;

  assign kx      = st[NW].qx[FRAC_BITS +: LW];
  assign ky      = st[NW].qy[FRAC_BITS +: LH];
  assign fx      = st[NW].qx[FRAC_BITS-1:0];
  assign fy      = st[NW].qy[FRAC_BITS-1:0];
  assign kx_inc  = (LW+1)'(kx) + 1'b1;
  assign ky_inc  = (LH+1)'(ky) + 1'b1;
  assign load_ok = (32'(st[NW].col) < 32'(MAX_WIDTH)) && (32'(st[NW].row) < 32'(MAX_HEIGHT));

  logic [PIX_W-1:0] rd [4];

  // Four banks by column and row parity, so that each neighbour has a bank of its own.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = b[0];
    localparam logic BY = b[1];
    logic [PIX_W-1:0]     mem [BANK_D];
    logic [LW:0]          xs;
    logic [LH:0]          ys;
    logic [BCW+BRW-1:0]   raddr;
    logic [BCW+BRW-1:0]   waddr;
    logic                 wen;

    assign xs    = (kx[0] == BX) ? (LW+1)'(kx) : kx_inc;
    assign ys    = (ky[0] == BY) ? (LH+1)'(ky) : ky_inc;
    assign raddr = {BRW'(ys >> 1), BCW'(xs >> 1)};
    assign waddr = {BRW'(st[NW].row >> 1), BCW'(st[NW].col >> 1)};
    assign wen   = st[NW].valid && st[NW].load && load_ok &&
                   (st[NW].col[0] == BX) && (st[NW].row[0] == BY);

    always_ff @(posedge clk) begin
      if (advance) begin
        if (wen) begin
          mem[waddr] <= st[NW].pix;
        end else if (st[NW].valid && !st[NW].load) begin
          rd[b] <= mem[raddr];
        end
      end
    end
  end

  // Memory stage registers.
  logic                 m_valid;
  logic                 m_err;
  logic                 m_kx0;
  logic                 m_ky0;
  logic                 m_xlast;
  logic                 m_ylast;
  logic [FRAC_BITS-1:0] m_fx;
  logic [FRAC_BITS-1:0] m_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= st[NW].valid && !st[NW].load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_err   <= st[NW].err;
      m_kx0   <= kx[0];
      m_ky0   <= ky[0];
      m_xlast <= (SWW'(kx) == sw_last);
      m_ylast <= (SHW'(ky) == sh_last);
      m_fx    <= fx;
      m_fy    <= fy;
    end
  end

  // Edge cases fold into the bilinear form by repeating neighbours.
  logic [PIX_W-1:0] pa;
  logic [PIX_W-1:0] pb;
  logic [PIX_W-1:0] pc;
  logic [PIX_W-1:0] pd;
  logic [FW-1:0]    wfy;

  always_comb begin
    pa  = rd[{m_ky0, m_kx0}];
    pb  = m_ylast ? pa : rd[{!m_ky0, m_kx0}];
    pc  = m_xlast ? pa : rd[{m_ky0, !m_kx0}];
    pd  = m_xlast ? pb : (m_ylast ? pc : rd[{!m_ky0, !m_kx0}]);
    wfy = FW'(2 ** FRAC_BITS) - FW'(m_fy);
  end

  // Vertical pass.
  logic                 v_valid;
  logic                 v_err;
  logic [FRAC_BITS-1:0] v_fx;
  logic [PW-1:0]        v_p0;
  logic [PW-1:0]        v_p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
    end else if (advance) begin
      v_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      v_err <= m_err;
      v_fx  <= m_fx;
      v_p0  <= PW'(pa) * PW'(wfy) + PW'(pb) * PW'(m_fy);
      v_p1  <= PW'(pc) * PW'(wfy) + PW'(pd) * PW'(m_fy);
    end
  end

  // Horizontal weighting.
  logic          h_valid;
  logic          h_err;
  logic [MW-1:0] h_m0;
  logic [MW-1:0] h_m1;
  logic [FW-1:0] wfx;

  assign wfx = FW'(2 ** FRAC_BITS) - FW'(v_fx);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (advance) begin
      h_valid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      h_err <= v_err;
      h_m0  <= MW'(v_p0) * MW'(wfx);
      h_m1  <= MW'(v_p1) * MW'(v_fx);
    end
  end

  // Sum, truncate and hold the result until the transaction completes.
  logic [MW:0] h_sum;

  assign h_sum = (MW+1)'(h_m0) + (MW+1)'(h_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_err <= h_err;
      out_pix <= h_err ? '0 : PIX_W'(h_sum >> (2 * FRAC_BITS));
    end
  end

endmodule

>>> hdl/bis_checker.sv
// Port-level checks for the bilinear image scaler, bound to the top level.
// Depends on bilinear_image_scaler and bis_pkg.
module bis_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pready,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [7:0]                  m_tdata,
  input logic                        m_tuser
);
  import bis_pkg::*;

  // A result waiting for its transaction keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A flagged coordinate carries a zero pixel.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0)
    else $error("error result with non-zero pixel");

  // Nothing leaves the block in the cycle after reset.
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown straight after reset");

  // The register port never waits.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

  // Output stalls reach the input only after the queue has filled.
  a_backpress: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !m_tvalid && $past(!m_tvalid) && $past(!s_tvalid) |-> s_tready)
    else $error("input refused while the block drains freely");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
  .clk, .rst, .pready, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);

>>> dv/bilinear_image_scaler_tb.sv
// Self-checking testbench for the bilinear image scaler: it loads source pixels, asks for
// output pixels under several register settings and checks each result against its own model.
// Depends on bis_pkg and the bilinear_image_scaler RTL.
`timescale 1ns / 1ps

module bilinear_image_scaler_tb;
  import bis_pkg::*;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int FB = 12;
  localparam int SETTLE = 120;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic       act;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] pix;
  } pixel_op_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       err;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tuser;

  // Register copies, the predicted frame store and the stimulus-side record of written pixels.
  logic [8:0] src_w = RST_SRC_WIDTH;
  logic [8:0] src_h = RST_SRC_HEIGHT;
  logic [15:0] scale = RST_SCALE;
  logic [7:0] store_px [0:MAXW*MAXH-1];
  bit written [0:MAXW*MAXH-1];

  pixel_op_t pending_ops[$];
  pixel_res_t expected_px[$];
  bit failed = 1'b0;
  bit calm = 1'b0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  bilinear_image_scaler dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  always #2 clk = ~clk;

  // Output sizes after saturation of the source registers and of the scaled product.
  function automatic void out_size(output longint unsigned sw, sh, ow, oh);
    sw = (src_w > MAXW) ? MAXW : src_w;
    sh = (src_h > MAXH) ? MAXH : src_h;
    ow = (sw * scale) >> SCALE_FRAC;
    oh = (sh * scale) >> SCALE_FRAC;
    if (ow > MAXW) ow = MAXW;
    if (oh > MAXH) oh = MAXH;
  endfunction

  // Interpolates one output pixel; all_written tells whether every source pixel read was loaded.
  function automatic pixel_res_t interpolate(input logic [7:0] c, r, output bit all_written);
    longint unsigned sw, sh, ow, oh, px, py, kx, ky, fx, fy, a, b, cc, d, val, one;
    pixel_res_t res;
    one = 64'd1 << FB;
    out_size(sw, sh, ow, oh);
    all_written = 1'b1;
    res = '{pixel: 8'd0, err: 1'b1};
    if (c >= ow || r >= oh) return res;
    px = ((c * sw) << FB) / ow;
    py = ((r * sh) << FB) / oh;
    kx = px >> FB;
    ky = py >> FB;
    fx = px & (one - 1);
    fy = py & (one - 1);
    a = store_px[ky*MAXW + kx];
    all_written = written[ky*MAXW + kx];
    if (ky != sh - 1 && kx != sw - 1) begin
      b = store_px[(ky+1)*MAXW + kx];
      cc = store_px[ky*MAXW + kx + 1];
      d = store_px[(ky+1)*MAXW + kx + 1];
      all_written &= written[(ky+1)*MAXW + kx] & written[ky*MAXW + kx + 1]
                     & written[(ky+1)*MAXW + kx + 1];
      val = ((a * (one - fy) + b * fy) * (one - fx) + (cc * (one - fy) + d * fy) * fx)
            >> (2 * FB);
    end else if (kx != sw - 1) begin
      cc = store_px[ky*MAXW + kx + 1];
      all_written &= written[ky*MAXW + kx + 1];
      val = (a * (one - fx) + cc * fx) >> FB;
    end else if (ky != sh - 1) begin
      b = store_px[(ky+1)*MAXW + kx];
      all_written &= written[(ky+1)*MAXW + kx];
      val = (a * (one - fy) + b * fy) >> FB;
    end else begin
      val = a;
    end
    res = '{pixel: val[7:0], err: 1'b0};
    return res;
  endfunction

  // Stimulus helpers: a load marks its pixel written; a compute that would read an
  // unloaded pixel is moved outside the output image instead.
  task automatic queue_load(input logic [7:0] c, r, p);
    pending_ops.push_back('{act: ACT_LOAD, col: c, row: r, pix: p});
    written[r*MAXW + c] = 1'b1;
  endtask

  task automatic queue_compute(input logic [7:0] c, r);
    bit ok;
    pixel_res_t unused;
    unused = interpolate(c, r, ok);
    if (!ok) begin
      c = 8'd255;
      r = 8'd255;
    end
    pending_ops.push_back('{act: ACT_COMPUTE, col: c, row: r, pix: 8'($urandom)});
  endtask

  task automatic load_region(input int w, h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) queue_load(8'(x), 8'(y), 8'($urandom));
  endtask

  // Waits until the block has drained, then for its pipeline to settle.
  task automatic drain();
    wait (pending_ops.size() == 0 && !s_tvalid && expected_px.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  src_w = value[8:0];
      REG_SRC_HEIGHT: src_h = value[8:0];
      REG_SCALE:      scale = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int w, h, s);
    drain();
    apb_write(REG_SRC_WIDTH, w);
    apb_write(REG_SRC_HEIGHT, h);
    apb_write(REG_SCALE, s);
  endtask

  // Mostly in-range computes, with loads anywhere and some computes with random coordinates.
  task automatic random_traffic(input int n);
    longint unsigned sw, sh, ow, oh;
    int pick;
    out_size(sw, sh, ow, oh);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        if ($urandom_range(0, 1))
          queue_load(8'($urandom_range(0, sw - 1)), 8'($urandom_range(0, sh - 1)), 8'($urandom));
        else
          queue_load(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 8) begin
        queue_compute(8'($urandom_range(0, ow)), 8'($urandom_range(0, oh)));
      end else begin
        queue_compute(8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Scenario sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a 2x2 patch at the origin, the origin and out-of-range corners.
    load_region(2, 2);
    queue_compute(8'd0, 8'd0);
    queue_compute(8'd255, 8'd255);
    queue_compute(8'd128, 8'd0);
    queue_compute(8'd0, 8'd128);
    queue_load(8'd255, 8'd255, 8'hFF);

    // Unit scale on 8x6: interior, last row, last column, corner and both out-of-range edges.
    set_config(8, 6, 4096);
    load_region(8, 6);
    queue_compute(8'd3, 8'd2);
    queue_compute(8'd4, 8'd5);
    queue_compute(8'd7, 8'd1);
    queue_compute(8'd7, 8'd5);
    queue_compute(8'd8, 8'd0);
    queue_compute(8'd0, 8'd6);

    // Oversized width register saturates; one source row, only the pixels read are loaded.
    set_config(511, 1, 4096);
    queue_load(8'd255, 8'd0, 8'($urandom));
    queue_load(8'd100, 8'd0, 8'($urandom));
    queue_load(8'd101, 8'd0, 8'($urandom));
    queue_compute(8'd255, 8'd0);
    queue_compute(8'd100, 8'd0);
    random_traffic(20);

    // Largest scale factor with a single source column; output height saturates.
    set_config(1, 256, 65535);
    queue_load(8'd0, 8'd255, 8'($urandom));
    queue_load(8'd0, 8'd200, 8'($urandom));
    queue_load(8'd0, 8'd201, 8'($urandom));
    queue_compute(8'd0, 8'd255);
    queue_compute(8'd14, 8'd200);
    random_traffic(20);

    // Empty output images: zero register and smallest scale factor.
    set_config(0, 3, 4096);
    queue_compute(8'd0, 8'd0);
    set_config(3, 3, 1);
    queue_compute(8'd0, 8'd0);
    queue_compute(8'd255, 8'd255);

    // Random settings; the sequence waits for the block to drain between them.
    for (int ph = 0; ph < 5; ph++) begin
      set_config($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1024, 20000));
      if (ph == 4) calm = 1'b1;
      load_region(src_w, src_h);
      random_traffic(35);
    end

    drain();
    if (!failed) begin
      $display("[bilinear_image_scaler] OK");
    end else begin
      $display("[bilinear_image_scaler] ERROR");
    end
    $finish;
  end

  // Sender: feeds the queue, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 13);
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        pixel_op_t op;
        op = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= op.act;
        s_tdata <= {op.pix, op.row, op.col};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Input monitor: updates the predicted store on loads, predicts a result on computes.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      bit ok;
      if (s_tuser == ACT_LOAD) begin
        store_px[s_tdata[15:8]*MAXW + s_tdata[7:0]] <= s_tdata[23:16];
      end else begin
        expected_px.push_back(interpolate(s_tdata[7:0], s_tdata[15:8], ok));
      end
    end
  end

  // Output monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pixel_res_t want;
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected result pixel=%0d error=%0b", $time, m_tdata, m_tuser);
        failed = 1'b1;
      end else begin
        want = expected_px.pop_front();
        if (want.pixel !== m_tdata || want.err !== m_tuser) begin
          $display("%0t: mismatch expected pixel=%0d error=%0b actual pixel=%0d error=%0b",
                   $time, want.pixel, want.err, m_tdata, m_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[bilinear_image_scaler] ERROR");
      $finish;
    end
  end

endmodule
